@@ design/irpd_pkg.sv @@
package irpd_pkg;

    // Payload capacity in 32-bit words
    localparam int PAYLOAD_WORDS = 3;
    localparam int PAY_BITS      = PAYLOAD_WORDS * 32;
    localparam int CNT_W         = $clog2(PAY_BITS + 1);
    localparam int OUT_WORDS     = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int TOL_W = 7;
    localparam int DUR_W = 16;
    localparam int NOM_W = 12;
    // (100 + tol) * nominal fits in 20 bits; 100 * duration + 99 in 23 bits
    localparam int BND_W = 20;
    localparam int SCL_W = 23;

    localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;

    localparam int NUM_NOM    = 5;
    localparam int NOM_HMARK  = 0;
    localparam int NOM_HSPACE = 1;
    localparam int NOM_BMARK  = 2;
    localparam int NOM_ONE    = 3;
    localparam int NOM_ZERO   = 4;

    localparam logic [NOM_W-1:0] NOMINAL [NUM_NOM] = '{
        12'd3120, 12'd1570, 12'd560, 12'd1060, 12'd260
    };

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MAGIC,
        PH_PAYLOAD,
        PH_DONE,
        PH_FAILED
    } t_phase;

    // Classified pulse pair, front to back
    typedef struct packed {
        logic hdr_ok;
        logic bit_ok;
        logic bit_one;
        logic last;
    } t_cls;

    typedef struct packed {
        logic [BND_W-1:0] lo;
        logic [BND_W-1:0] hi;
    } t_bnd;

    // Window bounds scaled by 100: d in window iff 100d+99 >= lo and 100d <= hi
    function automatic t_bnd calc_bnd(logic [TOL_W-1:0] tol, logic [NOM_W-1:0] nom);
        t_bnd b;
        b.hi = BND_W'(8'd100 + {1'b0, tol}) * BND_W'(nom);
        if (tol >= 7'd100) begin
            b.lo = '0;
        end else begin
            b.lo = BND_W'(8'd100 - {1'b0, tol}) * BND_W'(nom);
        end
        return b;
    endfunction

    function automatic logic in_window(logic [DUR_W-1:0] d, t_bnd b);
        logic [SCL_W-1:0] s;
        s = (SCL_W'(d) << 6) + (SCL_W'(d) << 5) + (SCL_W'(d) << 2);
        return ((s + SCL_W'(99)) >= SCL_W'(b.lo)) && (s <= SCL_W'(b.hi));
    endfunction

endpackage

@@ design/ir_pulse_distance_frame_decoder_top.sv @@
// Infrared pulse-distance frame decoder. Each transaction on the input channel is one
// measured mark/space pair; the pair flagged last produces one result transaction with
// validity, the magic word, three payload words and the payload bit count. The block
// takes one pair per cycle: the front end checks both durations against the tolerance
// windows in the accepting cycle and writes the classified pair into a two-entry queue,
// and the frame sequencer retires one queued pair per cycle unless a final pair waits
// on a stalled output. A result is registered at the edge at which its final pair
// leaves the queue. Input ready drops only when the queue is full, which happens when
// a result is held by a stalled output and further pairs arrive. Writing the tolerance
// register updates the window bounds at the same clock edge.
module ir_pulse_distance_frame_decoder_top
    import irpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_mark_us,
    input  logic [15:0] i_space_us,
    input  logic        i_last_pair,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_valid,
    output logic [31:0] o_magic_word,
    output logic [31:0] o_payload_low,
    output logic [31:0] o_payload_mid,
    output logic [31:0] o_payload_high,
    output logic [6:0]  o_payload_bit_count
);

    t_cls cls;
    t_cls head;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic q_push;

    assign o_in_ready = !q_full;
    assign q_push     = i_in_valid && !q_full;

    irpd_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mark_us     (i_mark_us),
        .i_space_us    (i_space_us),
        .i_last_pair   (i_last_pair),
        .o_cls         (cls)
    );

    irpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    irpd_frame u_frame (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (q_empty),
        .i_head              (head),
        .o_pop               (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_frame_valid       (o_frame_valid),
        .o_magic_word        (o_magic_word),
        .o_payload_low       (o_payload_low),
        .o_payload_mid       (o_payload_mid),
        .o_payload_high      (o_payload_high),
        .o_payload_bit_count (o_payload_bit_count)
    );

endmodule

@@ design/irpd_classify.sv @@
module irpd_classify
    import irpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TOL_W-1:0] i_cfg_wr_data,
    input  logic [DUR_W-1:0] i_mark_us,
    input  logic [DUR_W-1:0] i_space_us,
    input  logic             i_last_pair,
    output t_cls             o_cls
);

    t_bnd r_bnd [NUM_NOM];

    // Bounds follow the written tolerance at the same edge
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_NOM; k++) begin
            if (!i_rst_n) begin
                r_bnd[k] <= calc_bnd(TOL_RESET, NOMINAL[k]);
            end else if (i_cfg_wr_en) begin
                r_bnd[k] <= calc_bnd(i_cfg_wr_data, NOMINAL[k]);
            end
        end
    end

    logic bit_mark;
    logic is_one;
    logic is_zero;

    always_comb begin
        bit_mark     = in_window(i_mark_us, r_bnd[NOM_BMARK]);
        is_one       = bit_mark && in_window(i_space_us, r_bnd[NOM_ONE]);
        is_zero      = bit_mark && in_window(i_space_us, r_bnd[NOM_ZERO]);
        o_cls.hdr_ok = in_window(i_mark_us, r_bnd[NOM_HMARK])
                       && in_window(i_space_us, r_bnd[NOM_HSPACE]);
        o_cls.bit_ok  = is_one || is_zero;
        o_cls.bit_one = is_one;
        o_cls.last    = i_last_pair;
    end

endmodule

@@ design/irpd_queue.sv @@
module irpd_queue
    import irpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_item,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cls o_head
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> (r_wr_ptr == $past(r_wr_ptr)))
        else $error("queue write pointer moved while full");
`endif

endmodule

@@ design/irpd_frame.sv @@
module irpd_frame
    import irpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cls        i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_valid,
    output logic [31:0] o_magic_word,
    output logic [31:0] o_payload_low,
    output logic [31:0] o_payload_mid,
    output logic [31:0] o_payload_high,
    output logic [6:0]  o_payload_bit_count
);

    t_phase                          r_phase;
    t_phase                          n_phase;
    logic [CNT_W-1:0]                r_pos;
    logic [CNT_W-1:0]                n_pos;
    logic [31:0]                     r_magic;
    logic [31:0]                     n_magic;
    logic [PAYLOAD_WORDS-1:0][31:0]  r_store;
    logic [PAYLOAD_WORDS-1:0][31:0]  n_store;

    logic                            r_out_valid;
    logic                            r_frame_valid;
    logic [31:0]                     r_magic_out;
    logic [OUT_WORDS-1:0][31:0]      r_words;
    logic [6:0]                      r_count;

    logic                            res_valid;
    logic [OUT_WORDS-1:0][31:0]      res_words;
    logic [6:0]                      res_count;

    // A non-final pair always drains; the final one needs the output slot
    assign o_pop = !i_empty && (!i_head.last || !r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEADER: begin
                n_phase = i_head.hdr_ok ? PH_MAGIC : PH_FAILED;
            end
            PH_MAGIC: begin
                if (!i_head.bit_ok) begin
                    n_phase = PH_FAILED;
                end else if (r_pos == CNT_W'(31)) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (!i_head.bit_ok || r_pos == CNT_W'(PAY_BITS - 1)) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Datapath updates for the pair at the head
    always_comb begin
        n_pos   = r_pos;
        n_magic = r_magic;
        n_store = r_store;
        unique case (r_phase)
            PH_MAGIC: begin
                if (i_head.bit_ok) begin
                    if (i_head.bit_one) begin
                        n_magic[r_pos[4:0]] = 1'b1;
                    end
                    n_pos = (r_pos == CNT_W'(31)) ? '0 : r_pos + 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (i_head.bit_ok) begin
                    for (int w = 0; w < PAYLOAD_WORDS; w++) begin
                        if (i_head.bit_one && r_pos[CNT_W-1:5] == (CNT_W-5)'(w)) begin
                            n_store[w][r_pos[4:0]] = 1'b1;
                        end
                    end
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_comb begin
        res_valid = (n_phase == PH_PAYLOAD) || (n_phase == PH_DONE);
        res_words = '0;
        res_count = '0;
        if (res_valid) begin
            for (int w = 0; w < OUT_WORDS; w++) begin
                if (w < PAYLOAD_WORDS) begin
                    res_words[w] = n_store[w];
                end
            end
            res_count = (n_pos > CNT_W'(127)) ? 7'd127 : 7'(n_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_magic <= '0;
            r_store <= '0;
        end else if (o_pop) begin
            if (i_head.last) begin
                r_phase <= PH_HEADER;
                r_pos   <= '0;
                r_magic <= '0;
                r_store <= '0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_magic <= n_magic;
                r_store <= n_store;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_frame_valid <= res_valid;
            r_magic_out   <= res_valid ? n_magic : '0;
            r_words       <= res_words;
            r_count       <= res_count;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_valid       = r_frame_valid;
    assign o_magic_word        = r_magic_out;
    assign o_payload_low       = r_words[0];
    assign o_payload_mid       = r_words[1];
    assign o_payload_high      = r_words[2];
    assign o_payload_bit_count = r_count;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_pop && i_head.last))
        else $error("result raised without a final pair");
    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos == '0 && r_magic == '0))
        else $error("stale frame state while awaiting header");
    a_magic_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MAGIC) |-> (r_pos < CNT_W'(32)))
        else $error("magic bit position out of range");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_frame_valid) |-> (r_magic_out == '0 && r_count == '0))
        else $error("invalid frame carries data");
`endif

endmodule
